// ===== src/iwr_pkg.sv =====
`timescale 1ns / 1ps

package iwr_pkg;

  localparam int IDX_W  = 21;
  localparam int VAL_W  = 21;
  localparam int SD_W   = 16;
  localparam int PD_W   = 31;
  localparam int WID_W  = 32;
  localparam int NODE_W = 17;
  localparam int SRC_W  = 16;
  localparam int THR_W  = 17;
  localparam int POS_W  = 21;
  localparam int DEG_W  = 21;
  localparam int CNT_W  = 5;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_WALKS  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [1:0] KIND_NEXT   = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_DANGLE = 2'd2;

  localparam logic [NODE_W-1:0] DANGLE_NODE = '1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_WR_OFF  = 2'd1,
    CMD_WR_EDGE = 2'd2,
    CMD_VISIT   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_WR_OFF,
    OP_WR_EDGE,
    OP_VISIT
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_OFF,
    S_DIV,
    S_EDGE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [SD_W-1:0]  stop_draw;
    logic [PD_W-1:0]  pick_draw;
  } item_t;

  typedef struct packed {
    logic [SRC_W-1:0] source_node;
    logic [WID_W-1:0] walks_total;
    logic [THR_W-1:0] stop_threshold;
  } cfg_t;

endpackage

// ===== src/iwr_front.sv =====
`timescale 1ns / 1ps

module iwr_front #(
  parameter int MAX_NODES = 65536,
  parameter int MAX_EDGES = 1048576
) (
  input  logic                  start,
  input  logic                  full,
  input  logic [1:0]            cmd,
  input  logic [20:0]           table_index,
  input  logic [20:0]           table_value,
  input  logic [15:0]           stop_draw,
  input  logic [30:0]           pick_draw,
  output logic                  push,
  output iwr_pkg::item_t        item
);
  import iwr_pkg::*;

  logic [31:0] idx_wide;

  assign idx_wide = {11'b0, table_index};
  assign push     = start && !full;

  // Classify the command; out-of-range table writes turn into no-ops.
  always_comb begin
    item.index     = table_index;
    item.value     = table_value;
    item.stop_draw = stop_draw;
    item.pick_draw = pick_draw;
    case (cmd_t'(cmd))
      CMD_START:   item.op = OP_START;
      CMD_WR_OFF:  item.op = (idx_wide <= 32'(MAX_NODES)) ? OP_WR_OFF : OP_NOP;
      CMD_WR_EDGE: item.op = (idx_wide < 32'(MAX_EDGES)) ? OP_WR_EDGE : OP_NOP;
      CMD_VISIT:   item.op = OP_VISIT;
      default:     item.op = OP_NOP;
    endcase
  end

endmodule

// ===== src/iwr_queue.sv =====
`timescale 1ns / 1ps

module iwr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  iwr_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output iwr_pkg::item_t head
);
  import iwr_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/iwr_div.sv =====
`timescale 1ns / 1ps

module iwr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [30:0] dividend,
  input  logic [20:0] divisor,
  output logic        done,
  output logic [20:0] rem
);
  import iwr_pkg::*;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [30:0]      num_r, num_nxt;
  logic [20:0]      den_r, den_nxt;
  logic [20:0]      rem_r, rem_nxt;
  logic [21:0]      trial;

  assign done = done_r;
  assign rem  = rem_r;
  assign trial = {rem_r, num_r[30]};

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(30);
      num_nxt = dividend;
      den_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 21'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = trial[20:0];
      end
      num_nxt = {num_r[29:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== src/iwr_back.sv =====
`timescale 1ns / 1ps

module iwr_back #(
  parameter int RING_SLOTS = 64,
  parameter int MAX_NODES  = 65536,
  parameter int MAX_EDGES  = 1048576
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  iwr_pkg::item_t      q_item,
  output logic                q_pop,
  input  iwr_pkg::cfg_t       cfg,
  output logic                out_valid,
  output logic [31:0]         out_walker_id,
  output logic [1:0]          out_kind,
  output logic signed [16:0]  out_node,
  output logic                out_all_done,
  output logic                out_last
);
  import iwr_pkg::*;

  localparam int SLOT_W  = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int OFF_AW  = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  state_t state_r, state_nxt;

  logic [RING_SLOTS-1:0] busy_r, busy_nxt;
  logic [RING_SLOTS-1:0] fresh_r, fresh_nxt;
  logic [SLOT_W-1:0]     ptr_r, ptr_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [WID_W-1:0]      next_walker_r, next_walker_nxt;
  logic [WID_W-1:0]      completed_r, completed_nxt;
  logic [SRC_W-1:0]      start_src_r, start_src_nxt;
  logic [WID_W-1:0]      cur_walker_r, cur_walker_nxt;
  logic                  pos_ok_r, pos_ok_nxt;
  item_t                 item_r, item_nxt;

  // Memories and their registered read data.
  logic [VAL_W-1:0] off_mem  [MAX_NODES+1];
  logic [VAL_W-1:0] edge_mem [MAX_EDGES];
  logic [WID_W-1:0] sw_mem   [RING_SLOTS];
  logic [POS_W-1:0] sp_mem   [RING_SLOTS];
  logic [VAL_W-1:0] lo_q, hi_q, edge_q;
  logic [WID_W-1:0] sw_q;
  logic [POS_W-1:0] sp_q;

  logic              off_we, edge_we, slot_re, slot_we, off_re, edge_re, div_go;
  logic [OFF_AW-1:0] off_ra0, off_ra1;
  logic [EDGE_AW-1:0] edge_ra;

  // Result register.
  logic              ov_r, ov_nxt;
  logic [WID_W-1:0]  ow_r, ow_nxt;
  logic [1:0]        ok_r, ok_nxt;
  logic [NODE_W-1:0] on_r, on_nxt;
  logic              od_r, od_nxt;
  logic              ol_r, ol_nxt;

  // Slot visit helpers.
  logic [WID_W-1:0] walker_rd, w_new;
  logic [POS_W-1:0] pos_rd, p_new;
  logic             b0, stop_hit, b1, take, b2;
  logic [WID_W-1:0] comp_stop;
  logic             off_dangle;
  logic [DEG_W-1:0] degree;
  logic             div_done;
  logic [DEG_W-1:0] div_rem;
  logic [21:0]      esum;
  logic             edge_ok;

  assign walker_rd = fresh_r[cur_r] ? WID_W'(cur_r) : sw_q;
  assign pos_rd    = fresh_r[cur_r] ? POS_W'(start_src_r) : sp_q;
  assign b0        = busy_r[cur_r];
  assign stop_hit  = b0 && ({1'b0, item_r.stop_draw} < cfg.stop_threshold);
  assign b1        = b0 && !stop_hit;
  assign take      = !b1 && (next_walker_r < cfg.walks_total);
  assign b2        = b1 || take;
  assign w_new     = take ? next_walker_r : walker_rd;
  assign p_new     = take ? POS_W'(cfg.source_node) : pos_rd;
  assign comp_stop = completed_r + WID_W'(stop_hit);
  assign off_dangle = !pos_ok_r || (hi_q <= lo_q);
  assign degree    = hi_q - lo_q;
  assign esum      = {1'b0, lo_q} + {1'b0, div_rem};
  assign edge_ok   = (32'(esum) < 32'(MAX_EDGES));

  iwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (item_r.pick_draw),
    .divisor  (degree),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid && q_item.op == OP_VISIT) state_nxt = S_SLOT;
      S_SLOT: state_nxt = b2 ? S_OFF : S_IDLE;
      S_OFF:  state_nxt = off_dangle ? S_IDLE : S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = edge_ok ? S_EDGE : S_IDLE;
      end
      S_EDGE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop           = 1'b0;
    busy_nxt        = busy_r;
    fresh_nxt       = fresh_r;
    ptr_nxt         = ptr_r;
    cur_nxt         = cur_r;
    next_walker_nxt = next_walker_r;
    completed_nxt   = completed_r;
    start_src_nxt   = start_src_r;
    cur_walker_nxt  = cur_walker_r;
    pos_ok_nxt      = pos_ok_r;
    item_nxt        = item_r;
    off_we  = 1'b0;
    edge_we = 1'b0;
    slot_re = 1'b0;
    slot_we = 1'b0;
    off_re  = 1'b0;
    edge_re = 1'b0;
    div_go  = 1'b0;
    off_ra0 = OFF_AW'(p_new);
    off_ra1 = OFF_AW'(p_new) + OFF_AW'(1);
    edge_ra = EDGE_AW'(esum);
    ov_nxt = 1'b0;
    ow_nxt = cur_walker_r;
    ok_nxt = KIND_NEXT;
    on_nxt = DANGLE_NODE;
    od_nxt = (completed_r == cfg.walks_total);
    ol_nxt = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          case (q_item.op)
            OP_START: begin
              for (int i = 0; i < RING_SLOTS; i++) begin
                busy_nxt[i] = (32'(i) < cfg.walks_total);
              end
              fresh_nxt       = '1;
              ptr_nxt         = '0;
              completed_nxt   = '0;
              start_src_nxt   = cfg.source_node;
              next_walker_nxt = (cfg.walks_total < 32'(RING_SLOTS)) ?
                                cfg.walks_total : 32'(RING_SLOTS);
            end
            OP_WR_OFF:  off_we = 1'b1;
            OP_WR_EDGE: edge_we = 1'b1;
            OP_VISIT: begin
              slot_re = 1'b1;
              cur_nxt = ptr_r;
              ptr_nxt = (ptr_r == SLOT_W'(RING_SLOTS - 1)) ? '0 : ptr_r + SLOT_W'(1);
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        // Stop test first, then refill a freed slot, then start the move.
        if (stop_hit) begin
          ov_nxt = 1'b1;
          ow_nxt = walker_rd;
          ok_nxt = KIND_STOP;
          on_nxt = pos_rd[NODE_W-1:0];
          od_nxt = (comp_stop == cfg.walks_total);
          ol_nxt = !b2;
        end
        completed_nxt   = comp_stop;
        busy_nxt[cur_r] = b2;
        if (take) next_walker_nxt = next_walker_r + WID_W'(1);
        cur_walker_nxt = w_new;
        pos_ok_nxt     = ({11'b0, p_new} < 32'(MAX_NODES));
        off_re         = b2 && ({11'b0, p_new} < 32'(MAX_NODES));
      end
      S_OFF: begin
        if (off_dangle) begin
          busy_nxt[cur_r] = 1'b0;
          completed_nxt   = completed_r + WID_W'(1);
          ov_nxt = 1'b1;
          ok_nxt = KIND_DANGLE;
          od_nxt = (completed_nxt == cfg.walks_total);
        end else begin
          div_go = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (edge_ok) begin
            edge_re = 1'b1;
          end else begin
            busy_nxt[cur_r] = 1'b0;
            completed_nxt   = completed_r + WID_W'(1);
            ov_nxt = 1'b1;
            ok_nxt = KIND_DANGLE;
            od_nxt = (completed_nxt == cfg.walks_total);
          end
        end
      end
      S_EDGE: begin
        slot_we          = 1'b1;
        fresh_nxt[cur_r] = 1'b0;
        ov_nxt = 1'b1;
        ok_nxt = KIND_NEXT;
        on_nxt = edge_q[NODE_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      busy_r        <= '0;
      fresh_r       <= '0;
      ptr_r         <= '0;
      next_walker_r <= '0;
      completed_r   <= '0;
      ov_r          <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      busy_r        <= busy_nxt;
      fresh_r       <= fresh_nxt;
      ptr_r         <= ptr_nxt;
      next_walker_r <= next_walker_nxt;
      completed_r   <= completed_nxt;
      ov_r          <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_src_r  <= start_src_nxt;
    cur_walker_r <= cur_walker_nxt;
    pos_ok_r     <= pos_ok_nxt;
    item_r       <= item_nxt;
    ow_r         <= ow_nxt;
    ok_r         <= ok_nxt;
    on_r         <= on_nxt;
    od_r         <= od_nxt;
    ol_r         <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (off_we) off_mem[OFF_AW'(q_item.index)] <= q_item.value;
    if (off_re) begin
      lo_q <= off_mem[off_ra0];
      hi_q <= off_mem[off_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[EDGE_AW'(q_item.index)] <= q_item.value;
    if (edge_re) edge_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      sw_mem[cur_r] <= cur_walker_r;
      sp_mem[cur_r] <= edge_q;
    end
    if (slot_re) begin
      sw_q <= sw_mem[ptr_r];
      sp_q <= sp_mem[ptr_r];
    end
  end

  assign out_valid     = ov_r;
  assign out_walker_id = ow_r;
  assign out_kind      = ok_r;
  assign out_node      = on_r;
  assign out_all_done  = od_r;
  assign out_last      = ol_r;

  a_dangle_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && ok_r == KIND_DANGLE |-> ol_r)
    else $error("dangling end not marked last");

  a_first_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !ol_r |-> ok_r == KIND_STOP)
    else $error("non-final result is not a stop");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("remainder finished outside divide state");

  a_completed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    completed_r <= next_walker_r)
    else $error("more walkers completed than launched");

endmodule

// ===== src/interleaved_walker_ring_engine_top.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// command   | start / busy           | in_cmd, in_table_index, in_table_value,
//           |                        | in_stop_draw, in_pick_draw
// result    | out_valid (strobe)     | out_walker_id, out_kind, out_node,
//           |                        | out_all_done, out_last
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Start, table writes and no-op writes retire without leaving the idle state.
// A visit that moves its walker holds the back end through pop, slot read,
// offset pair read, bit-serial remainder by the node degree, and edge read;
// an empty slot retires after the slot read, a dangling row after the offsets.
// rst_n is synchronous; it clears the ring, counters and queue; tables are
// undefined until written. The two-entry command queue raises busy when full;
// results are single-cycle strobes that the receiver cannot hold off.
module interleaved_walker_ring_engine_top #(
  parameter int RING_SLOTS = 64,
  parameter int MAX_NODES  = 65536,
  parameter int MAX_EDGES  = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [20:0]        in_table_index,
  input  logic [20:0]        in_table_value,
  input  logic [15:0]        in_stop_draw,
  input  logic [30:0]        in_pick_draw,
  output logic               out_valid,
  output logic [31:0]        out_walker_id,
  output logic [1:0]         out_kind,
  output logic signed [16:0] out_node,
  output logic               out_all_done,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import iwr_pkg::*;

  cfg_t  cfg_r;
  item_t push_item, head_item;
  logic  push, full, not_empty, pop;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_node    <= '0;
      cfg_r.walks_total    <= 32'd1;
      cfg_r.stop_threshold <= 17'd9830;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE: cfg_r.source_node    <= cfg_data[SRC_W-1:0];
        REG_WALKS:  cfg_r.walks_total    <= cfg_data;
        REG_THRESH: cfg_r.stop_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify the command and push it into the queue.
  iwr_front #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_front (
    .start       (start),
    .full        (full),
    .cmd         (in_cmd),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .stop_draw   (in_stop_draw),
    .pick_draw   (in_pick_draw),
    .push        (push),
    .item        (push_item)
  );

  assign busy = full;

  // Short queue so the front keeps taking transfers while the back walks.
  iwr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_item)
  );

  // Back end: ring state, tables, degree remainder and result register.
  iwr_back #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (not_empty),
    .q_item        (head_item),
    .q_pop         (pop),
    .cfg           (cfg_r),
    .out_valid     (out_valid),
    .out_walker_id (out_walker_id),
    .out_kind      (out_kind),
    .out_node      (out_node),
    .out_all_done  (out_all_done),
    .out_last      (out_last)
  );

endmodule
